### sv/uct_pkg.sv
// Shared types, codes and default sizes for the unread counter table.
// Used by every module of the block but uct_ram; depends on nothing else.
`default_nettype none

package uct_pkg;

   // Default sizes handed to the top level parameters.
   localparam int CHANNEL_COUNT_DEF = 32;
   localparam int PEER_SLOTS_DEF    = 12;
   localparam int COUNT_BITS_DEF    = 16;

   // Request codes.
   localparam logic [2:0] OP_MARK        = 3'd0;
   localparam logic [2:0] OP_QUERY_PEER  = 3'd1;
   localparam logic [2:0] OP_CLEAR_PEER  = 3'd2;
   localparam logic [2:0] OP_QUERY_CHAN  = 3'd3;
   localparam logic [2:0] OP_CLEAR_CHAN  = 3'd4;
   localparam logic [2:0] OP_RESET_ALL   = 3'd5;

   // Message direction codes.
   localparam logic [1:0] DIR_INCOMING   = 2'd0;
   localparam logic [1:0] DIR_BROADCAST  = 2'd1;

   // Result status codes.
   localparam logic [1:0] ST_COUNTED     = 2'd0;
   localparam logic [1:0] ST_IGNORED     = 2'd1;
   localparam logic [1:0] ST_NOSLOT      = 2'd2;
   localparam logic [1:0] ST_DONE        = 2'd3;

   // Request transaction payload.
   typedef struct packed {
      logic [2:0]        req_type;
      logic [1:0]        direction;
      logic signed [7:0] channel_number;
      logic [31:0]       peer_address;
   } req_type_type;

   // Result transaction payload.
   typedef struct packed {
      logic [15:0] counter_value;
      logic [1:0]  status;
   } rsp_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_READ,
      ST_EXEC
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic lookup;
      logic exec;
   } cmd_type;

endpackage

`default_nettype wire

### sv/uct_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module uct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/uct_ctrl.sv
// Controller state machine for the unread counter table.
// Depends on uct_pkg for the state and command types.
`default_nettype none

module uct_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output uct_pkg::cmd_type       cmd
);

   uct_pkg::ctrl_state_type state_ff;
   uct_pkg::ctrl_state_type state_in;

   // Next state: capture, lookup, memory read, then execute and respond.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         uct_pkg::ST_IDLE: begin
            if (start) begin
               state_in = uct_pkg::ST_LOOKUP;
            end
         end
         uct_pkg::ST_LOOKUP: begin
            state_in = uct_pkg::ST_READ;
         end
         uct_pkg::ST_READ: begin
            state_in = uct_pkg::ST_EXEC;
         end
         uct_pkg::ST_EXEC: begin
            state_in = uct_pkg::ST_IDLE;
         end
         default: begin
            state_in = uct_pkg::ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uct_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs decoded from the current state.
   always_comb begin
      busy        = 1'b1;
      cmd.capture = 1'b0;
      cmd.lookup  = 1'b0;
      cmd.exec    = 1'b0;
      case (state_ff)
         uct_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         uct_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         uct_pkg::ST_READ: begin
            busy = 1'b1;
         end
         uct_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/uct_dpath.sv
// Datapath of the unread counter table: peer key match, counter RAMs and result.
// Depends on uct_pkg and instantiates uct_ram for both counter stores.
`default_nettype none

module uct_dpath #(
   parameter int CHANNEL_COUNT = uct_pkg::CHANNEL_COUNT_DEF,
   parameter int PEER_SLOTS    = uct_pkg::PEER_SLOTS_DEF,
   parameter int COUNT_BITS    = uct_pkg::COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire uct_pkg::cmd_type      cmd,
   input  wire uct_pkg::req_type_type req_data,
   output logic                       rsp_strobe,
   output uct_pkg::rsp_type           rsp_data
);

   localparam int CH_AW = $clog2(CHANNEL_COUNT > 1 ? CHANNEL_COUNT : 2);
   localparam int SL_AW = $clog2(PEER_SLOTS > 1 ? PEER_SLOTS : 2);

   // Captured request.
   uct_pkg::req_type_type req_ff;

   // Lookup results.
   logic [SL_AW-1:0]      slot_ff,     slot_in;
   logic                  hit_ff,      hit_in;
   logic                  free_ok_ff,  free_ok_in;
   logic                  direct_ff,   direct_in;
   logic                  chan_ok_ff,  chan_ok_in;
   logic [CH_AW-1:0]      chan_addr_ff, chan_addr_in;

   // Peer keys and channel valid bits.
   logic [31:0]            keys_ff [PEER_SLOTS];
   logic [CHANNEL_COUNT-1:0] chan_valid_ff;

   // Result register.
   logic                  rsp_valid_ff;
   uct_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   // Lookup combinational signals.
   logic [SL_AW-1:0]      match_idx;
   logic                  match_any;
   logic [SL_AW-1:0]      free_idx;
   logic                  free_any;
   logic                  chan_in_range;
   logic                  is_mark;

   // Memory ports.
   logic                  peer_wr_en;
   logic [COUNT_BITS-1:0] peer_wr_data;
   logic [COUNT_BITS-1:0] peer_rd_data;
   logic                  chan_wr_en;
   logic [COUNT_BITS-1:0] chan_wr_data;
   logic [COUNT_BITS-1:0] chan_rd_data;

   // Execute stage values.
   logic [COUNT_BITS-1:0] chan_old;
   logic [COUNT_BITS-1:0] chan_new;
   logic [COUNT_BITS-1:0] peer_new;

   // Capture the request when it is accepted.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // Parallel key compare with lowest-index priority, plus first free slot.
   always_comb begin
      match_idx = '0;
      match_any = 1'b0;
      free_idx  = '0;
      free_any  = 1'b0;
      for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
         if (keys_ff[i] == req_ff.peer_address && req_ff.peer_address != 32'd0) begin
            match_idx = SL_AW'(i);
            match_any = 1'b1;
         end
         if (keys_ff[i] == 32'd0) begin
            free_idx = SL_AW'(i);
            free_any = 1'b1;
         end
      end
   end

   // Request decode for the lookup stage.
   always_comb begin
      is_mark       = (req_ff.req_type == uct_pkg::OP_MARK);
      chan_in_range = ({24'd0, req_ff.channel_number} < 32'(CHANNEL_COUNT));
      direct_in     = is_mark && req_ff.direction == uct_pkg::DIR_INCOMING
                      && req_ff.channel_number[7] && req_ff.peer_address != 32'd0;
      hit_in        = match_any;
      free_ok_in    = free_any;
      slot_in       = match_any ? match_idx : free_idx;
      if (is_mark && req_ff.direction == uct_pkg::DIR_BROADCAST) begin
         chan_addr_in = '0;
         chan_ok_in   = 1'b1;
      end else begin
         chan_addr_in = req_ff.channel_number[CH_AW-1:0];
         if (is_mark) begin
            chan_ok_in = (req_ff.direction == uct_pkg::DIR_INCOMING) && chan_in_range;
         end else begin
            chan_ok_in = chan_in_range;
         end
      end
   end

   // Lookup stage registers.
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         slot_ff      <= slot_in;
         hit_ff       <= hit_in;
         free_ok_ff   <= free_ok_in;
         direct_ff    <= direct_in;
         chan_ok_ff   <= chan_ok_in;
         chan_addr_ff <= chan_addr_in;
      end
   end

   // Counter stores.
   uct_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (PEER_SLOTS)
   ) u_peer_ram (
      .clock   (clock),
      .wr_en   (peer_wr_en),
      .wr_addr (slot_ff),
      .wr_data (peer_wr_data),
      .rd_addr (slot_ff),
      .rd_data (peer_rd_data)
   );

   uct_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (CHANNEL_COUNT)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (chan_wr_en),
      .wr_addr (chan_addr_ff),
      .wr_data (chan_wr_data),
      .rd_addr (chan_addr_ff),
      .rd_data (chan_rd_data)
   );

   // Saturating increments; a channel never written since its last clear reads zero.
   always_comb begin
      chan_old = chan_valid_ff[chan_addr_ff] ? chan_rd_data : '0;
      chan_new = (&chan_old) ? chan_old : chan_old + COUNT_BITS'(1);
      peer_new = (&peer_rd_data) ? peer_rd_data : peer_rd_data + COUNT_BITS'(1);
   end

   // Execute stage: memory writes and the result.
   always_comb begin
      peer_wr_en   = 1'b0;
      peer_wr_data = hit_ff ? peer_new : COUNT_BITS'(1);
      chan_wr_en   = 1'b0;
      chan_wr_data = chan_new;
      rsp_data_in.counter_value = 16'd0;
      rsp_data_in.status        = uct_pkg::ST_DONE;
      case (req_ff.req_type)
         uct_pkg::OP_MARK: begin
            if (direct_ff) begin
               if (hit_ff || free_ok_ff) begin
                  peer_wr_en                = cmd.exec;
                  rsp_data_in.counter_value = 16'(peer_wr_data);
                  rsp_data_in.status        = uct_pkg::ST_COUNTED;
               end else begin
                  rsp_data_in.status = uct_pkg::ST_NOSLOT;
               end
            end else if (chan_ok_ff) begin
               chan_wr_en                = cmd.exec;
               rsp_data_in.counter_value = 16'(chan_new);
               rsp_data_in.status        = uct_pkg::ST_COUNTED;
            end else begin
               rsp_data_in.status = uct_pkg::ST_IGNORED;
            end
         end
         uct_pkg::OP_QUERY_PEER: begin
            if (hit_ff) begin
               rsp_data_in.counter_value = 16'(peer_rd_data);
            end
         end
         uct_pkg::OP_QUERY_CHAN: begin
            if (chan_ok_ff) begin
               rsp_data_in.counter_value = 16'(chan_old);
            end
         end
         uct_pkg::OP_CLEAR_PEER,
         uct_pkg::OP_CLEAR_CHAN,
         uct_pkg::OP_RESET_ALL: begin
            rsp_data_in.status = uct_pkg::ST_DONE;
         end
         default: begin
            rsp_data_in.status = uct_pkg::ST_IGNORED;
         end
      endcase
   end

   // Peer keys and channel valid bits, cleared by reset and by reset all.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PEER_SLOTS; i++) begin
            keys_ff[i] <= 32'd0;
         end
         chan_valid_ff <= '0;
      end else if (cmd.exec) begin
         case (req_ff.req_type)
            uct_pkg::OP_MARK: begin
               if (direct_ff && !hit_ff && free_ok_ff) begin
                  keys_ff[slot_ff] <= req_ff.peer_address;
               end
               if (!direct_ff && chan_ok_ff) begin
                  chan_valid_ff[chan_addr_ff] <= 1'b1;
               end
            end
            uct_pkg::OP_CLEAR_PEER: begin
               if (hit_ff) begin
                  keys_ff[slot_ff] <= 32'd0;
               end
            end
            uct_pkg::OP_CLEAR_CHAN: begin
               if (chan_ok_ff) begin
                  chan_valid_ff[chan_addr_ff] <= 1'b0;
               end
            end
            uct_pkg::OP_RESET_ALL: begin
               for (int i = 0; i < PEER_SLOTS; i++) begin
                  keys_ff[i] <= 32'd0;
               end
               chan_valid_ff <= '0;
            end
            default: begin
               chan_valid_ff <= chan_valid_ff;
            end
         endcase
      end
   end

   // Result register: one strobe per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

### sv/unread_counter_table.sv
// The result strobe rises after the request has passed the lookup, the
// registered read of the counter RAMs and the read-modify-write that follows
// it; busy is high until then, so a new request waits for the last one.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset is synchronous and clears peer keys and channel valid bits at once,
// so no clearing pass is needed and a request may start right after reset.
`default_nettype none

module unread_counter_table #(
   parameter int CHANNEL_COUNT = uct_pkg::CHANNEL_COUNT_DEF,
   parameter int PEER_SLOTS    = uct_pkg::PEER_SLOTS_DEF,
   parameter int COUNT_BITS    = uct_pkg::COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire uct_pkg::req_type_type req_data,
   output logic                       rsp_strobe,
   output uct_pkg::rsp_type           rsp_data
);

   uct_pkg::cmd_type cmd;

   // Sequencer.
   uct_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Counter stores and result logic.
   uct_dpath #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .PEER_SLOTS    (PEER_SLOTS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTH
   // Every accepted transaction gets its result strobe.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("result strobe missing after accepted transaction");

   // The block stays busy for the whole lookup, read and execute sequence.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 busy ##1 busy)
      else $error("busy dropped while a transaction was in flight");

   // A result is only given out once the work of its transaction is done.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && $past(busy))
      else $error("result strobe outside the end of a transaction");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for unread_counter_table: directed and random requests
// are compared against an in-bench model of the counter and peer tables.
// Depends on uct_pkg and the unread_counter_table RTL only.
`timescale 1ns / 100ps

module tb;

   // Sizes of the stores, taken from the package defaults used by the DUT.
   localparam int NUM_CHANNELS = uct_pkg::CHANNEL_COUNT_DEF;
   localparam int NUM_SLOTS    = uct_pkg::PEER_SLOTS_DEF;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // Codes that the package does not name.
   localparam logic [2:0] OP_RSVD_6  = 3'd6;
   localparam logic [2:0] OP_RSVD_7  = 3'd7;
   localparam logic [1:0] DIR_OTHER  = 2'd2;
   localparam logic [1:0] DIR_SPARE  = 2'd3;

   localparam int IDLE_PERCENT   = 21;
   localparam int STALL_LIMIT    = 1000;
   localparam int RANDOM_ITEMS   = 620;
   localparam int REPEAT_MARKS   = 20;
   localparam int MAX_REPORTS    = 10;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PEER_POOL_SIZE = 16;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   uct_pkg::req_type_type req_data = '0;
   logic                  rsp_strobe;
   uct_pkg::rsp_type      rsp_data;

   // Model state of the counter and peer tables.
   logic [15:0] chan_unread [NUM_CHANNELS];
   logic [31:0] peer_key    [NUM_SLOTS];
   logic [15:0] peer_unread [NUM_SLOTS];

   uct_pkg::rsp_type pending_results [$];
   logic [31:0]      peer_pool [PEER_POOL_SIZE];
   bit               idle_on = 1'b0;
   int               error_count = 0;
   int               request_count = 0;
   int               checked_count = 0;
   int               status_tally [4];
   int               stall_cycles = 0;

   unread_counter_table DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Returns the slot that holds a peer, or -1; peer 0 never matches.
   function automatic int find_peer_slot(logic [31:0] addr);
      if (addr == '0) begin
         return -1;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (peer_key[i] == addr) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic logic [15:0] saturating_inc(logic [15:0] v);
      return (v == COUNT_MAX) ? COUNT_MAX : v + 16'd1;
   endfunction

   function automatic void clear_tables();
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         chan_unread[i] = '0;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         peer_key[i]    = '0;
         peer_unread[i] = '0;
      end
   endfunction

   // Applies one request to the model tables and returns the result it gives.
   function automatic uct_pkg::rsp_type apply_request(uct_pkg::req_type_type r);
      uct_pkg::rsp_type res;
      int               slot;
      int               chan;
      int               target;
      res.counter_value = '0;
      res.status        = uct_pkg::ST_DONE;
      chan = $signed(r.channel_number);
      case (r.req_type)
         uct_pkg::OP_MARK: begin
            if (r.direction == uct_pkg::DIR_INCOMING && chan < 0
                && r.peer_address != '0) begin
               // Direct message: count on the peer's slot, claiming the lowest free one.
               slot = find_peer_slot(r.peer_address);
               if (slot < 0) begin
                  for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                     if (peer_key[i] == '0) begin
                        slot = i;
                     end
                  end
                  if (slot >= 0) begin
                     peer_key[slot]    = r.peer_address;
                     peer_unread[slot] = '0;
                  end
               end
               if (slot < 0) begin
                  res.status = uct_pkg::ST_NOSLOT;
               end else begin
                  peer_unread[slot] = saturating_inc(peer_unread[slot]);
                  res.counter_value = peer_unread[slot];
                  res.status        = uct_pkg::ST_COUNTED;
               end
            end else begin
               // Channel message: broadcasts land on channel 0.
               target = -1;
               if (r.direction == uct_pkg::DIR_BROADCAST) begin
                  target = 0;
               end else if (r.direction == uct_pkg::DIR_INCOMING) begin
                  target = chan;
               end
               if (target < 0 || target >= NUM_CHANNELS) begin
                  res.status = uct_pkg::ST_IGNORED;
               end else begin
                  chan_unread[target] = saturating_inc(chan_unread[target]);
                  res.counter_value   = chan_unread[target];
                  res.status          = uct_pkg::ST_COUNTED;
               end
            end
         end
         uct_pkg::OP_QUERY_PEER: begin
            slot = find_peer_slot(r.peer_address);
            if (slot >= 0) begin
               res.counter_value = peer_unread[slot];
            end
         end
         uct_pkg::OP_CLEAR_PEER: begin
            slot = find_peer_slot(r.peer_address);
            if (slot >= 0) begin
               peer_key[slot]    = '0;
               peer_unread[slot] = '0;
            end
         end
         uct_pkg::OP_QUERY_CHAN: begin
            if (chan >= 0 && chan < NUM_CHANNELS) begin
               res.counter_value = chan_unread[chan];
            end
         end
         uct_pkg::OP_CLEAR_CHAN: begin
            if (chan >= 0 && chan < NUM_CHANNELS) begin
               chan_unread[chan] = '0;
            end
         end
         uct_pkg::OP_RESET_ALL: begin
            clear_tables();
         end
         default: begin
            res.status = uct_pkg::ST_IGNORED;
         end
      endcase
      return res;
   endfunction

   function automatic uct_pkg::req_type_type make_req(logic [2:0] op, logic [1:0] dir,
                                                      logic [7:0] chan,
                                                      logic [31:0] peer);
      uct_pkg::req_type_type r;
      r.req_type       = op;
      r.direction      = dir;
      r.channel_number = chan;
      r.peer_address   = peer;
      return r;
   endfunction

   // Sends one request transaction, with an optional idle gap before it, and
   // records the expected result once the DUT takes it.
   task automatic send_request(input uct_pkg::req_type_type r);
      int gap;
      if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         gap = $urandom_range(1, 7);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      pending_results.push_back(apply_request(r));
      request_count++;
   endtask

   task automatic report_mismatch(input string what, input uct_pkg::rsp_type want,
                                  input uct_pkg::rsp_type got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: %s: expected count %0d status %0d, got count %0d status %0d",
                  $realtime, what, want.counter_value, want.status,
                  got.counter_value, got.status);
      end
   endtask

   // Each result is compared with the oldest outstanding expectation.
   always @(posedge clock) begin : check_results
      uct_pkg::rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            want = '0;
            report_mismatch("result with no request outstanding", want, rsp_data);
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            status_tally[want.status]++;
            if (rsp_data.counter_value !== want.counter_value) begin
               report_mismatch("counter_value mismatch", want, rsp_data);
            end else if (rsp_data.status !== want.status) begin
               report_mismatch("status mismatch", want, rsp_data);
            end
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Channel marks, broadcasts, other directions, and channel query and clear.
   task automatic test_channel_marks();
      send_request(make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING, 8'd0, 32'd0));
      send_request(make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING, 8'd31, 32'hFFFF_FFFF));
      send_request(make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING, 8'd32, 32'd0));
      send_request(make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING, 8'd127, 32'd7));
      // A direct message from peer 0 falls through and is ignored.
      send_request(make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING, 8'h80, 32'd0));
      send_request(make_req(uct_pkg::OP_MARK, uct_pkg::DIR_BROADCAST, 8'hFF, 32'hFFFF_FFFF));
      send_request(make_req(uct_pkg::OP_MARK, DIR_OTHER, 8'd0, 32'd5));
      send_request(make_req(uct_pkg::OP_MARK, DIR_SPARE, 8'hFF, 32'd5));
      send_request(make_req(uct_pkg::OP_QUERY_CHAN, uct_pkg::DIR_INCOMING, 8'd0, 32'd0));
      send_request(make_req(uct_pkg::OP_QUERY_CHAN, DIR_SPARE, 8'd32, 32'd0));
      send_request(make_req(uct_pkg::OP_QUERY_CHAN, uct_pkg::DIR_INCOMING, 8'h80, 32'd0));
      send_request(make_req(uct_pkg::OP_CLEAR_CHAN, uct_pkg::DIR_INCOMING, 8'd31, 32'd0));
      send_request(make_req(uct_pkg::OP_CLEAR_CHAN, uct_pkg::DIR_INCOMING, 8'hC8, 32'd0));
      send_request(make_req(uct_pkg::OP_QUERY_CHAN, uct_pkg::DIR_INCOMING, 8'd31, 32'd0));
   endtask

   // Peer table: claim, match, full table, query, clear and slot reuse.
   task automatic test_peer_table();
      send_request(make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING, 8'hFF, 32'hFFFF_FFFF));
      send_request(make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING, 8'h80, 32'hFFFF_FFFF));
      for (int i = 1; i < NUM_SLOTS; i++) begin
         send_request(make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING, 8'hFF, i));
      end
      send_request(make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING, 8'hFF, 32'h1234_5678));
      send_request(make_req(uct_pkg::OP_QUERY_PEER, uct_pkg::DIR_INCOMING, 8'd0,
                            32'hFFFF_FFFF));
      send_request(make_req(uct_pkg::OP_QUERY_PEER, uct_pkg::DIR_INCOMING, 8'd0, 32'd0));
      send_request(make_req(uct_pkg::OP_QUERY_PEER, uct_pkg::DIR_INCOMING, 8'd0,
                            32'h1234_5678));
      send_request(make_req(uct_pkg::OP_CLEAR_PEER, uct_pkg::DIR_INCOMING, 8'd0, 32'd3));
      send_request(make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING, 8'hFF, 32'h1234_5678));
      send_request(make_req(uct_pkg::OP_CLEAR_PEER, uct_pkg::DIR_INCOMING, 8'd0,
                            32'h0BAD_0001));
      send_request(make_req(uct_pkg::OP_CLEAR_PEER, uct_pkg::DIR_INCOMING, 8'd0, 32'd0));
   endtask

   // Undefined request codes and the global reset request.
   task automatic test_undefined_and_reset_all();
      send_request(make_req(OP_RSVD_6, uct_pkg::DIR_INCOMING, 8'd0, 32'd1));
      send_request(make_req(OP_RSVD_7, DIR_SPARE, 8'hFF, 32'hFFFF_FFFF));
      send_request(make_req(uct_pkg::OP_RESET_ALL, uct_pkg::DIR_INCOMING, 8'd0, 32'd0));
      send_request(make_req(uct_pkg::OP_QUERY_PEER, uct_pkg::DIR_INCOMING, 8'd0,
                            32'hFFFF_FFFF));
      send_request(make_req(uct_pkg::OP_QUERY_CHAN, uct_pkg::DIR_INCOMING, 8'd0, 32'd0));
   endtask

   // Repeated marks on one channel and one peer, back to back.
   task automatic test_back_to_back_marks();
      idle_on = 1'b0;
      for (int i = 0; i < REPEAT_MARKS; i++) begin
         send_request(make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING, 8'd5, 32'd0));
      end
      for (int i = 0; i < REPEAT_MARKS; i++) begin
         send_request(make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING, 8'h9C,
                               32'hA5A5_0001));
      end
      send_request(make_req(uct_pkg::OP_QUERY_CHAN, uct_pkg::DIR_INCOMING, 8'd5, 32'd0));
      send_request(make_req(uct_pkg::OP_QUERY_PEER, uct_pkg::DIR_INCOMING, 8'd0,
                            32'hA5A5_0001));
      send_request(make_req(uct_pkg::OP_RESET_ALL, uct_pkg::DIR_INCOMING, 8'd0, 32'd0));
   endtask

   // Random traffic, with direct marks from a small peer pool as its largest share so the
   // table fills, overflows and churns; the rest covers every request and field.
   task automatic test_random_traffic();
      uct_pkg::req_type_type r;
      int                    pick;
      logic [31:0]           peer;
      for (int i = 0; i < PEER_POOL_SIZE; i++) begin
         peer_pool[i] = ($urandom & 32'hFFFF_FFE0) | (i + 1);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on = !(n >= 250 && n < 350);
         pick = $urandom_range(99);
         peer = ($urandom_range(9) == 0) ? $urandom
                                         : peer_pool[$urandom_range(PEER_POOL_SIZE - 1)];
         if (pick < 45) begin
            r = make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING,
                         8'($urandom_range(128, 255)),
                         ($urandom_range(49) == 0) ? 32'd0 : peer);
         end else if (pick < 59) begin
            r = make_req(uct_pkg::OP_MARK, uct_pkg::DIR_INCOMING,
                         8'($urandom_range(0, 35)), $urandom);
         end else if (pick < 64) begin
            r = make_req(uct_pkg::OP_MARK, uct_pkg::DIR_BROADCAST, 8'($urandom), $urandom);
         end else if (pick < 67) begin
            r = make_req(uct_pkg::OP_MARK, 2'($urandom_range(2, 3)), 8'($urandom),
                         $urandom);
         end else if (pick < 74) begin
            r = make_req(uct_pkg::OP_QUERY_PEER, 2'($urandom), 8'($urandom), peer);
         end else if (pick < 81) begin
            r = make_req(uct_pkg::OP_CLEAR_PEER, 2'($urandom), 8'($urandom), peer);
         end else if (pick < 88) begin
            r = make_req(uct_pkg::OP_QUERY_CHAN, 2'($urandom),
                         ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 35)),
                         $urandom);
         end else if (pick < 94) begin
            r = make_req(uct_pkg::OP_CLEAR_CHAN, 2'($urandom),
                         ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 35)),
                         $urandom);
         end else if (pick < 95) begin
            r = make_req(uct_pkg::OP_RESET_ALL, 2'($urandom), 8'($urandom), $urandom);
         end else begin
            // Fully random fields, including the undefined request codes.
            r = make_req(3'($urandom), 2'($urandom), 8'($urandom), $urandom);
         end
         send_request(r);
      end
   endtask

   initial begin
      clear_tables();
      for (int i = 0; i < 4; i++) begin
         status_tally[i] = 0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_on = 1'b1;
      test_channel_marks();
      test_peer_table();
      test_undefined_and_reset_all();
      test_back_to_back_marks();
      test_random_traffic();

      // Drain: wait for every expected result, then for a further drain period.
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d results, %0d mismatches.",
               request_count, checked_count, error_count);
      $display("Results by status: counted %0d, ignored %0d, no slot %0d, done %0d.",
               status_tally[uct_pkg::ST_COUNTED], status_tally[uct_pkg::ST_IGNORED],
               status_tally[uct_pkg::ST_NOSLOT], status_tally[uct_pkg::ST_DONE]);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
